[src/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and codes for the population statistics engine.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_REPLACE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS1,
    S_DIV1,
    S_PASS2,
    S_DIV2,
    S_SQRT,
    S_DONE
  } state_e;

  // divider command from sequencer to divide unit
  typedef struct packed {
    logic start;
    logic sgn;
  } div_ctl_t;

endpackage

[src/pse_div.sv]
// ----------------------------------------------------------------------------
// pse_div
// Restoring divider, one quotient bit per cycle. Signed mode truncates
// toward zero; unsigned mode floors.
// ----------------------------------------------------------------------------
module pse_div
  import pse_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_ctl_t      ctl_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_q, q_d;
  logic [NW:0]   r_q, r_d;
  logic [DW-1:0] d_q, d_d;
  logic [CW-1:0] c_q, c_d;
  logic          neg_q, neg_d;
  logic          busy_q, busy_d;
  logic [NW:0]   trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    c_d    = c_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    trial  = '0;
    if (ctl_i.start) begin
      neg_d  = ctl_i.sgn & num_i[NW-1];
      q_d    = (ctl_i.sgn & num_i[NW-1]) ? (~num_i + 1'b1) : num_i;
      r_d    = '0;
      d_d    = den_i;
      c_d    = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {r_q[NW-1:0], q_q[NW-1]};
      q_d   = {q_q[NW-2:0], 1'b0};
      if (trial >= {{(NW+1-DW){1'b0}}, d_q}) begin
        r_d    = trial - {{(NW+1-DW){1'b0}}, d_q};
        q_d[0] = 1'b1;
      end else begin
        r_d = trial;
      end
      c_d = c_q - 1'b1;
      if (c_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      c_q    <= '0;
    end else begin
      busy_q <= busy_d;
      c_q    <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? (~q_q + 1'b1) : q_q;

endmodule

[src/pse_sqrt.sv]
// ----------------------------------------------------------------------------
// pse_sqrt
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pse_sqrt #(
  parameter int W = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   val_i,
  output logic           busy_o,
  output logic [W/2-1:0] root_o
);

  localparam int HW = W / 2;
  localparam int CW = $clog2(HW + 1);

  logic [W-1:0]  v_q, v_d;
  logic [HW-1:0] res_q, res_d;
  logic [HW+1:0] rem_q, rem_d;
  logic [CW-1:0] c_q, c_d;
  logic          busy_q, busy_d;
  logic [HW+1:0] trial, tsub;

  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    rem_d  = rem_q;
    c_d    = c_q;
    busy_d = busy_q;
    trial  = {rem_q[HW-1:0], v_q[W-1:W-2]};
    tsub   = {res_q, 2'b01};
    if (start_i) begin
      v_d    = val_i;
      res_d  = '0;
      rem_d  = '0;
      c_d    = CW'(HW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d = {v_q[W-3:0], 2'b00};
      if (trial >= tsub) begin
        rem_d = trial - tsub;
        res_d = {res_q[HW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        res_d = {res_q[HW-2:0], 1'b0};
      end
      c_d = c_q - 1'b1;
      if (c_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      c_q    <= '0;
    end else begin
      busy_q <= busy_d;
      c_q    <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign root_o = res_q;

endmodule

[src/population_stats_engine_unit.sv]
// ----------------------------------------------------------------------------
// population_stats_engine_unit
// Sample store with running count, sum, min, max, mean and deviation.
// ----------------------------------------------------------------------------
// Sequence: the result follows two passes over the store memory, two
//   divides and a square root; when empty it follows the first pass directly.
// Requests: one at a time; the next is taken in the cycle after the
//   result leaves.
// Reset: count and control clear; store contents are undefined until written.
module population_stats_engine_unit
  import pse_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  action_i,
  input  logic [4:0]  position_i,
  input  logic signed [15:0] sample_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [5:0]  entry_total_o,
  output logic signed [20:0] total_o,
  output logic signed [15:0] smallest_o,
  output logic signed [15:0] largest_o,
  output logic signed [15:0] average_o,
  output logic [15:0] deviation_o,
  output logic [1:0]  status_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int SW = 17 + NW;
  localparam int QW = 48;

  logic [15:0] mem [CAPACITY];
  logic [15:0] rd_q;

  state_e st_q, st_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] i_q, i_d;
  logic          rv_q, rv_d;
  logic [1:0]    stat_q, stat_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [15:0]   lo_q, lo_d, hi_q, hi_d, mean_q, mean_d;
  logic [QW-1:0] sq_q, sq_d;
  logic [15:0]   dev_q, dev_d;
  logic          ov_q, ov_d;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  div_ctl_t      dctl;
  logic [QW-1:0] dnum, dquo;
  logic          dbusy;
  logic          sq_start, sbusy;
  logic [23:0]   root;

  logic signed [16:0] dif;
  logic [16:0]   adif;
  logic [33:0]   prod;
  logic signed [15:0] x;
  logic          acc;

  assign acc   = valid_i && !stall_o;
  assign x     = signed'(rd_q);
  assign dif   = 17'(x) - 17'(mean_q);
  assign adif  = dif[16] ? 17'(-dif) : 17'(dif);
  assign prod  = 34'(adif) * 34'(adif);

  assign rd_addr = i_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= sample_i;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = n_q[AW-1:0];
    n_d     = n_q;
    stat_d  = stat_q;
    if (acc) begin
      stat_d = ST_OK;
      unique case (action_i)
        ACT_APPEND: begin
          if (n_q >= NW'(CAPACITY)) stat_d = ST_FULL;
          else begin
            wr_en = 1'b1;
            n_d   = n_q + 1'b1;
          end
        end
        ACT_REPLACE: begin
          if (32'(position_i) >= 32'(n_q) || 32'(position_i) >= CAPACITY) stat_d = ST_INDEX;
          else begin
            wr_en   = 1'b1;
            wr_addr = AW'(position_i);
          end
        end
        ACT_CLEAR: n_d = '0;
        default: ;
      endcase
    end else if (st_q == S_PASS1 && n_q == '0 && stat_q == ST_OK) begin
      stat_d = ST_EMPTY;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (acc) st_d = S_PASS1;
      S_PASS1: begin
        if (n_q == '0) st_d = S_DONE;
        else if (rv_q && i_q == n_q) st_d = S_DIV1;
      end
      S_DIV1:  if (!dbusy && !dctl.start) st_d = S_PASS2;
      S_PASS2: if (rv_q && i_q == n_q) st_d = S_DIV2;
      S_DIV2:  if (!dbusy && !dctl.start) st_d = S_SQRT;
      S_SQRT:  if (!sbusy && !sq_start) st_d = S_DONE;
      S_DONE:  if (!stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  logic ph_q, ph_d;

  always_comb begin
    i_d      = i_q;
    rv_d     = 1'b0;
    sum_d    = sum_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mean_d   = mean_q;
    sq_d     = sq_q;
    dev_d    = dev_q;
    ov_d     = 1'b0;
    ph_d     = ph_q;
    dctl     = '0;
    dnum     = QW'(sum_q);
    sq_start = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        i_d   = '0;
        sum_d = '0;
        lo_d  = '0;
        hi_d  = '0;
        mean_d = '0;
        sq_d  = '0;
        dev_d = '0;
        ph_d  = 1'b0;
      end
      S_PASS1, S_PASS2: begin
        if (i_q != n_q) begin
          i_d  = i_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          if (st_q == S_PASS1) begin
            sum_d = sum_q + SW'(x);
            if (i_q == NW'(1) || x < lo_q) lo_d = x;
            if (i_q == NW'(1) || x > hi_q) hi_d = x;
          end else begin
            sq_d = sq_q + QW'(prod);
          end
        end
        ph_d = 1'b0;
      end
      S_DIV1, S_DIV2: begin
        i_d = '0;
        if (!ph_q) begin
          dctl.start = 1'b1;
          dctl.sgn   = (st_q == S_DIV1);
          dnum       = (st_q == S_DIV1) ? QW'(sum_q) : sq_q;
          ph_d       = 1'b1;
        end else if (!dbusy) begin
          ph_d = 1'b0;
          if (st_q == S_DIV1) mean_d = dquo[15:0];
          else sq_d = dquo;
        end
      end
      S_SQRT: begin
        if (!ph_q) begin
          sq_start = 1'b1;
          ph_d     = 1'b1;
        end else if (!sbusy) begin
          dev_d = root[15:0];
        end
      end
      default: ;
    endcase
  end

  pse_div #(.NW(QW), .DW(NW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .num_i  (dnum),
    .den_i  (n_q),
    .busy_o (dbusy),
    .quo_o  (dquo)
  );

  pse_sqrt #(.W(QW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_q),
    .busy_o  (sbusy),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      n_q    <= '0;
      i_q    <= '0;
      rv_q   <= 1'b0;
      stat_q <= ST_OK;
      ph_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      n_q    <= n_d;
      i_q    <= i_d;
      rv_q   <= rv_d;
      stat_q <= stat_d;
      ph_q   <= ph_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mean_q <= mean_d;
    sq_q   <= sq_d;
    dev_q  <= dev_d;
  end

  localparam logic signed [SW-1:0] TMAX = SW'(1048575);
  localparam logic signed [SW-1:0] TMIN = -SW'(1048576);

  assign stall_o       = (st_q != S_IDLE) || ov_q;
  assign valid_o       = (st_q == S_DONE);
  assign entry_total_o = 6'(n_q);
  assign total_o       = (sum_q > TMAX) ? 21'(TMAX) : (sum_q < TMIN) ? 21'(TMIN) : 21'(sum_q);
  assign smallest_o    = lo_q;
  assign largest_o     = hi_q;
  assign average_o     = mean_q;
  assign deviation_o   = dev_q;
  assign status_o      = stat_q;

endmodule

[verif/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker
// Watches request and result channels of the statistics engine, keeps its own
// copy of the sample store, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module pse_checker
  import pse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               stall_o,
  input  logic [1:0]         action_i,
  input  logic [4:0]         position_i,
  input  logic signed [15:0] sample_i,
  input  logic               valid_o,
  input  logic               stall_i,
  input  logic [5:0]         entry_total_o,
  input  logic signed [20:0] total_o,
  input  logic signed [15:0] smallest_o,
  input  logic signed [15:0] largest_o,
  input  logic signed [15:0] average_o,
  input  logic [15:0]        deviation_o,
  input  logic [1:0]         status_o,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [5:0]         cnt;
    logic signed [20:0] sum;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] mean;
    logic [15:0]        dev;
    logic [1:0]         st;
  } stats_t;

  logic signed [15:0] store_q [DEPTH];
  int                 held_q;
  stats_t             stats_queue[$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = stats_queue.size();

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    for (longint b = 64'sd1 << 20; b > 0; b = b >> 1) begin
      if ((r + b) * (r + b) <= v) r = r + b;
    end
    return r;
  endfunction

  function automatic stats_t stats_of(logic [1:0] st);
    stats_t s;
    longint acc, m, sq, d;
    logic signed [15:0] lo, hi;
    s = '0;
    s.st = st;
    s.cnt = held_q[5:0];
    if (held_q == 0) begin
      if (st == ST_OK) s.st = ST_EMPTY;
      return s;
    end
    acc = 0;
    lo = store_q[0];
    hi = store_q[0];
    for (int i = 0; i < held_q; i++) begin
      acc += store_q[i];
      if (store_q[i] < lo) lo = store_q[i];
      if (store_q[i] > hi) hi = store_q[i];
    end
    m = acc / held_q;
    sq = 0;
    for (int i = 0; i < held_q; i++) begin
      d = store_q[i] - m;
      sq += d * d;
    end
    s.sum  = acc[20:0];
    s.lo   = lo;
    s.hi   = hi;
    s.mean = m[15:0];
    s.dev  = 16'(floor_sqrt(sq / held_q));
    return s;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    fails  = 0;
    held_q = 0;
  end

  always @(posedge clk_i) begin
    logic [1:0] st;
    stats_t     w;
    if (rst_ni && valid_i && !stall_o) begin
      st = ST_OK;
      case (action_i)
        ACT_APPEND: begin
          if (held_q >= DEPTH) st = ST_FULL;
          else begin
            store_q[held_q] = sample_i;
            held_q++;
          end
        end
        ACT_REPLACE: begin
          if (position_i >= held_q) st = ST_INDEX;
          else store_q[position_i] = sample_i;
        end
        ACT_CLEAR: held_q = 0;
        default: ;
      endcase
      stats_queue.push_back(stats_of(st));
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (stats_queue.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        fails++;
      end else begin
        w = stats_queue.pop_front();
        if (entry_total_o !== w.cnt) report("entry_total", entry_total_o, w.cnt);
        if (total_o !== w.sum) report("total", total_o, w.sum);
        if (smallest_o !== w.lo) report("smallest", smallest_o, w.lo);
        if (largest_o !== w.hi) report("largest", largest_o, w.hi);
        if (average_o !== w.mean) report("average", average_o, w.mean);
        if (deviation_o !== w.dev) report("deviation", deviation_o, w.dev);
        if (status_o !== w.st) report("status", status_o, w.st);
      end
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the statistics engine: directed corner requests, then random
// fill/replace/clear/no-op sequences with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic               clk_i, rst_ni;
  logic               valid_i, stall_o, valid_o, stall_i;
  logic [1:0]         action_i;
  logic [4:0]         position_i;
  logic signed [15:0] sample_i;
  logic [5:0]         entry_total_o;
  logic signed [20:0] total_o;
  logic signed [15:0] smallest_o, largest_o, average_o;
  logic [15:0]        deviation_o;
  logic [1:0]         status_o;
  int                 fail_count, pending, idle_cycles, model_held;
  logic               hold_long;

  population_stats_engine_unit DUT (.*);

  pse_checker u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send(logic [1:0] act, logic [4:0] pos, logic [15:0] smp);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i    <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    sample_i   <= smp;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
    case (act)
      ACT_APPEND: if (model_held < 32) model_held++;
      ACT_CLEAR:  model_held = 0;
      default: ;
    endcase
  endtask

  // receiver stalls
  initial begin
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        stall_i <= 1'b1;
        repeat (1500) @(negedge clk_i);
        stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [1:0] act;
    int         run;
    valid_i = 1'b0; action_i = ACT_APPEND; position_i = '0; sample_i = '0;
    rst_ni = 1'b0; hold_long = 1'b0; model_held = 0;
    idle_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed corners
    send(ACT_REPLACE, 5'd0, 16'h1234);
    send(ACT_NOP, 5'd31, 16'hFFFF);
    send(ACT_APPEND, 5'd31, 16'h8000);
    send(ACT_APPEND, 5'd0, 16'h7FFF);
    send(ACT_REPLACE, 5'd1, 16'h0000);
    send(ACT_REPLACE, 5'd2, 16'h5555);
    send(ACT_APPEND, 5'd0, 16'hFFFF);
    send(ACT_NOP, 5'd0, 16'h0);
    send(ACT_CLEAR, 5'd31, 16'h7FFF);
    hold_long = 1'b1;
    for (int i = 0; i < 33; i++) send(ACT_APPEND, 5'($urandom), (i % 2) ? 16'h7FFF : 16'h8000);
    send(ACT_REPLACE, 5'd31, 16'h7FFF);
    send(ACT_CLEAR, 5'd0, 16'h0);
    for (int i = 0; i < 33; i++) send(ACT_APPEND, 5'd0, 16'h7FFF);
    send(ACT_CLEAR, 5'd0, 16'h0);
    // random sequences
    for (int n = 0; n < 500; n++) begin
      run = $urandom_range(0, 99);
      if (run < 55) act = ACT_APPEND;
      else if (run < 85) act = ACT_REPLACE;
      else if (run < 92) act = ACT_CLEAR;
      else act = ACT_NOP;
      if (act == ACT_REPLACE && $urandom_range(0, 4) != 0 && model_held > 0)
        send(act, 5'($urandom_range(0, model_held - 1)), 16'($urandom));
      else
        send(act, 5'($urandom), ($urandom_range(0, 3) == 0) ?
             (($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000) : 16'($urandom));
    end
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
